// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL files; the point-check unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ed_pkg.sv -----
`default_nettype none
package ed_pkg;

  typedef logic [254:0] fe_t;

  localparam fe_t P    = 255'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffed;
  localparam fe_t PM1  = 255'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffec;
  localparam fe_t D    = 255'h52036cee2b6ffe738cc740797779e89800700a4d4141d8ab75eb4dca135978a3;
  localparam fe_t HALF = 255'h3ffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffff6;
  localparam fe_t ONE  = 255'h1;
  localparam logic [7:0] E_TOP = 8'd253;
  localparam int RF_DEPTH = 8;

  typedef enum logic [2:0] {A_Y, A_U, A_V, A_W, A_ACC} rf_addr_t;

  typedef enum logic [1:0] {OP_MUL, OP_SUB1, OP_ADD1, OP_ONE} op_t;

  typedef enum logic [2:0] {
    PC_SQY, PC_U, PC_DY, PC_V, PC_W, PC_ONE, PC_SQ, PC_MW
  } pc_t;

  typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_EXE, ST_MULW, ST_FIN, ST_OUT} seq_st_t;

  typedef enum logic [2:0] {M_IDLE, M_ACC, M_RED1, M_RED2, M_RED3} mul_st_t;

  typedef struct packed {
    logic     we;
    rf_addr_t waddr;
    fe_t      wdata;
    rf_addr_t raddr_a;
    rf_addr_t raddr_b;
  } rf_req_t;

  typedef struct packed {
    op_t      op;
    rf_addr_t a;
    rf_addr_t b;
    logic     bconst;
    rf_addr_t dst;
  } uop_t;

  function automatic uop_t uop_of(pc_t pc);
    uop_t u;
    u = '{op: OP_MUL, a: A_Y, b: A_Y, bconst: 1'b0, dst: A_Y};
    case (pc)
      PC_SQY: u = '{op: OP_MUL,  a: A_Y,   b: A_Y,   bconst: 1'b0, dst: A_Y};
      PC_U:   u = '{op: OP_SUB1, a: A_Y,   b: A_Y,   bconst: 1'b0, dst: A_U};
      PC_DY:  u = '{op: OP_MUL,  a: A_Y,   b: A_Y,   bconst: 1'b1, dst: A_V};
      PC_V:   u = '{op: OP_ADD1, a: A_V,   b: A_V,   bconst: 1'b0, dst: A_V};
      PC_W:   u = '{op: OP_MUL,  a: A_U,   b: A_V,   bconst: 1'b0, dst: A_W};
      PC_ONE: u = '{op: OP_ONE,  a: A_ACC, b: A_ACC, bconst: 1'b0, dst: A_ACC};
      PC_SQ:  u = '{op: OP_MUL,  a: A_ACC, b: A_ACC, bconst: 1'b0, dst: A_ACC};
      PC_MW:  u = '{op: OP_MUL,  a: A_ACC, b: A_W,   bconst: 1'b0, dst: A_ACC};
      default: u = '{op: OP_MUL, a: A_Y,   b: A_Y,   bconst: 1'b0, dst: A_Y};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ed_rf.sv -----
`default_nettype none
module ed_rf (
  input  wire             clk,
  input  ed_pkg::rf_req_t req,
  output ed_pkg::fe_t     rd_a,
  output ed_pkg::fe_t     rd_b
);
  import ed_pkg::*;

  fe_t mem [RF_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ed_mul.sv -----
`default_nettype none
module ed_mul (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  ed_pkg::fe_t a,
  input  ed_pkg::fe_t b,
  output logic        done,
  output ed_pkg::fe_t r
);
  import ed_pkg::*;

  mul_st_t      mst, mst_next;
  logic [2:0]   cnt;
  logic [255:0] aq, bq, hi, lo;
  logic [260:0] r1;
  logic [255:0] r2;

  logic [31:0]  bw;
  logic [63:0]  pp [8];
  logic [287:0] part;
  logic [287:0] sum;
  logic [511:0] full;
  logic [256:0] h;
  logic [260:0] r1_calc;
  logic [10:0]  top19;

  always_comb begin
    bw = bq[{cnt, 5'd0} +: 32];
    part = '0;
    for (int k = 0; k < 8; k++) begin
      pp[k] = {32'd0, aq[32*k +: 32]} * {32'd0, bw};
      part = part + (288'(pp[k]) << (32 * k));
    end
    sum = 288'(hi) + part;
    full = {hi, lo};
    h = full[511:255];
    r1_calc = 261'(full[254:0]) + (261'(h) << 4) + (261'(h) << 1) + 261'(h);
    top19 = 11'(r1[260:255]) * 11'd19;
  end

  always_comb begin
    mst_next = mst;
    case (mst)
      M_IDLE: if (start) mst_next = M_ACC;
      M_ACC:  if (cnt == 3'd7) mst_next = M_RED1;
      M_RED1: mst_next = M_RED2;
      M_RED2: mst_next = M_RED3;
      M_RED3: mst_next = M_IDLE;
      default: mst_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mst  <= M_IDLE;
      done <= 1'b0;
    end else begin
      mst  <= mst_next;
      done <= (mst == M_RED3);
    end
  end

  always_ff @(posedge clk) begin
    case (mst)
      M_IDLE: begin
        aq  <= {1'b0, a};
        bq  <= {1'b0, b};
        hi  <= '0;
        lo  <= '0;
        cnt <= '0;
      end
      M_ACC: begin
        hi  <= sum[287:32];
        lo  <= {sum[31:0], lo[255:32]};
        cnt <= cnt + 3'd1;
      end
      M_RED1: r1 <= r1_calc;
      M_RED2: r2 <= 256'(r1[254:0]) + 256'(top19);
      M_RED3: r  <= (r2 >= {1'b0, P}) ? 255'(r2 - {1'b0, P}) : r2[254:0];
      default: cnt <= '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ed25519_point_on_curve_check_unit.sv -----
`default_nettype none
`include "assert_macros.svh"
// Checks whether a compressed ed25519 point decodes to a curve point: the sign bit is
// dropped, y is reduced mod 2^255-19, and on_curve is 1 when y^2-1 is zero or
// (y^2-1)(d*y^2+1) is a quadratic residue. Working values sit in a small register-file
// memory; one 256x32-bit row multiplier, with a two-step fold and a final subtraction
// of p, reduces each product. One item takes 509 modular multiplications, each run as
// 8 rows, 3 reduction steps, a memory read and a write-back, plus three
// add/subtract/load steps and the steps to take the word and hand off the result.
// A new word is buffered while one is in work, and a finished result waits in its own
// register.
module ed25519_point_on_curve_check_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         y_valid,
  output logic        y_stall,
  input  wire  [63:0] y_word_0,
  input  wire  [63:0] y_word_1,
  input  wire  [63:0] y_word_2,
  input  wire  [63:0] y_word_3,
  output logic        result_valid,
  input  wire         result_stall,
  output logic        on_curve
);
  import ed_pkg::*;

  seq_st_t    state, state_next;
  pc_t        pc, pc_next;
  logic [7:0] ebit, ebit_next;
  logic       uz, uz_next;
  logic       ibuf_valid, ibuf_take, out_load, adv;
  fe_t        ybuf, y_red, rd_a, rd_b, mul_b, mul_r, sub1, add1;
  logic       mul_start, mul_done;
  rf_req_t    req;
  uop_t       uop;

  ed_rf u_rf (.clk(clk), .req(req), .rd_a(rd_a), .rd_b(rd_b));

  ed_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(rd_a), .b(mul_b),
    .done(mul_done), .r(mul_r)
  );

  assign y_stall = ibuf_valid;
  assign uop     = uop_of(pc);
  assign mul_b   = uop.bconst ? D : rd_b;
  assign y_red   = (ybuf >= P) ? ybuf - P : ybuf;
  assign sub1    = (rd_a == '0) ? PM1 : rd_a - ONE;
  assign add1    = (rd_a == PM1) ? '0 : rd_a + ONE;

  always_comb begin
    state_next = state;
    pc_next    = pc;
    ebit_next  = ebit;
    uz_next    = uz;
    adv        = 1'b0;
    mul_start  = 1'b0;
    ibuf_take  = 1'b0;
    out_load   = 1'b0;
    req.we      = 1'b0;
    req.waddr   = uop.dst;
    req.wdata   = mul_r;
    req.raddr_a = uop.a;
    req.raddr_b = uop.b;
    case (state)
      ST_IDLE: begin
        if (ibuf_valid) begin
          req.we     = 1'b1;
          req.waddr  = A_Y;
          req.wdata  = y_red;
          ibuf_take  = 1'b1;
          pc_next    = PC_SQY;
          state_next = ST_RD;
        end
      end
      ST_RD: state_next = ST_EXE;
      ST_EXE: begin
        case (uop.op)
          OP_MUL: begin
            mul_start  = 1'b1;
            state_next = ST_MULW;
          end
          OP_SUB1: begin
            req.we    = 1'b1;
            req.wdata = sub1;
            uz_next   = (rd_a == ONE);
            adv       = 1'b1;
          end
          OP_ADD1: begin
            req.we    = 1'b1;
            req.wdata = add1;
            adv       = 1'b1;
          end
          OP_ONE: begin
            req.we    = 1'b1;
            req.wdata = ONE;
            adv       = 1'b1;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_MULW: begin
        if (mul_done) begin
          req.we = 1'b1;
          adv    = 1'b1;
        end
      end
      ST_FIN: begin
        req.raddr_a = A_ACC;
        state_next  = ST_OUT;
      end
      ST_OUT: begin
        if (!result_valid || !result_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (adv) begin
      state_next = ST_RD;
      case (pc)
        PC_ONE: begin
          pc_next   = PC_SQ;
          ebit_next = E_TOP;
        end
        PC_SQ: begin
          if (HALF[ebit]) begin
            pc_next = PC_MW;
          end else if (ebit == '0) begin
            state_next = ST_FIN;
          end else begin
            ebit_next = ebit - 8'd1;
          end
        end
        PC_MW: begin
          if (ebit == '0) begin
            state_next = ST_FIN;
          end else begin
            ebit_next = ebit - 8'd1;
            pc_next   = PC_SQ;
          end
        end
        default: pc_next = pc_t'(pc + 3'd1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pc           <= PC_SQY;
      ebit         <= '0;
      uz           <= 1'b0;
      ibuf_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      ebit  <= ebit_next;
      uz    <= uz_next;
      if (y_valid && !y_stall) begin
        ibuf_valid <= 1'b1;
      end else if (ibuf_take) begin
        ibuf_valid <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (y_valid && !y_stall) begin
      ybuf <= {y_word_3[62:0], y_word_2, y_word_1, y_word_0};
    end
    if (out_load) begin
      on_curve <= uz | (rd_a == ONE);
    end
  end

  `ASSERT_IMPL(a_done_in_wait, mul_done, state == ST_MULW, "multiply done outside wait")
  `ASSERT_IMPL(a_mw_bit_set, (state == ST_EXE) && (pc == PC_MW), HALF[ebit],
               "multiply step on a clear exponent bit")
  `ASSERT_NEXT(a_start_seq, (state == ST_IDLE) && ibuf_valid,
               (state == ST_RD) && (pc == PC_SQY) && !ibuf_valid, "word not taken")

endmodule
`default_nettype wire

// ----- tb/ed25519_point_on_curve_check_unit_tb.sv -----
`timescale 1ns / 1ps
module ed25519_point_on_curve_check_unit_tb;
  import ed_pkg::*;

  typedef struct {
    logic [63:0] w0, w1, w2, w3;
    bit          drain;
  } point_word_t;

  localparam int NUM_RANDOM  = 270;
  localparam int QUIET_AFTER = 240;
  localparam int HOLD_AT     = 30;
  localparam int HOLD_CYCLES = 40000;
  localparam longint CYCLE_LIMIT = 8000000;

  logic        clk;
  logic        rst;
  logic        y_valid;
  logic        y_stall;
  logic [63:0] y_word_0, y_word_1, y_word_2, y_word_3;
  logic        result_valid;
  logic        result_stall;
  logic        on_curve;

  point_word_t pending_words[$];
  bit          expected_on_curve[$];
  int          errors;
  int          sent;
  int          send_gap;
  int          stall_burst;
  int          hold_left;
  bit          hold_done;
  longint      cycles;

  ed25519_point_on_curve_check_unit i_dut (
    .clk(clk), .rst(rst),
    .y_valid(y_valid), .y_stall(y_stall),
    .y_word_0(y_word_0), .y_word_1(y_word_1), .y_word_2(y_word_2), .y_word_3(y_word_3),
    .result_valid(result_valid), .result_stall(result_stall),
    .on_curve(on_curve)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic fe_t mod_mul(fe_t a, fe_t b);
    logic [509:0] prod;
    prod = {255'd0, a} * {255'd0, b};
    return fe_t'(prod % {255'd0, P});
  endfunction

  function automatic bit curve_membership(point_word_t pw);
    logic [255:0] raw;
    fe_t y, y2, u, v, w, acc;
    raw = {pw.w3, pw.w2, pw.w1, pw.w0};
    y = raw[254:0];
    if (y >= P) y = y - P;
    y2 = mod_mul(y, y);
    u = (y2 == 0) ? PM1 : y2 - 1;
    if (u == 0) return 1'b1;
    v = mod_mul(D, y2);
    v = (v == PM1) ? 0 : v + 1;
    w = mod_mul(u, v);
    acc = ONE;
    for (int i = 253; i >= 0; i--) begin
      acc = mod_mul(acc, acc);
      if (HALF[i]) acc = mod_mul(acc, w);
    end
    return acc == ONE;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic add_point(input logic [255:0] val, input bit drain);
    point_word_t pw;
    pw.w0 = val[63:0];
    pw.w1 = val[127:64];
    pw.w2 = val[191:128];
    pw.w3 = val[255:192];
    pw.drain = drain;
    pending_words.push_back(pw);
  endtask

  // sender
  always @(posedge clk) begin
    point_word_t pw;
    if (rst) begin
      y_valid <= 1'b0;
      y_word_0 <= '0;
      y_word_1 <= '0;
      y_word_2 <= '0;
      y_word_3 <= '0;
      send_gap = 0;
    end else begin
      if (y_valid && !y_stall) begin
        pw.w0 = y_word_0;
        pw.w1 = y_word_1;
        pw.w2 = y_word_2;
        pw.w3 = y_word_3;
        expected_on_curve.push_back(curve_membership(pw));
        sent++;
      end
      if (!y_valid || !y_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          y_valid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          y_valid <= 1'b0;
        end else if (pending_words[0].drain && expected_on_curve.size() != 0) begin
          y_valid <= 1'b0;
        end else begin
          pw = pending_words.pop_front();
          y_word_0 <= pw.w0;
          y_word_1 <= pw.w1;
          y_word_2 <= pw.w2;
          y_word_3 <= pw.w3;
          y_valid <= 1'b1;
          if (sent < QUIET_AFTER && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 7);
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_burst = 0;
      hold_left = 0;
      hold_done = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_on_curve.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else if (on_curve !== expected_on_curve[0]) begin
          report_mismatch($sformatf("on_curve %b, expected %b", on_curve,
                                    expected_on_curve[0]));
          void'(expected_on_curve.pop_front());
        end else begin
          void'(expected_on_curve.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (!hold_done && sent == HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        result_stall <= 1'b1;
      end else if (stall_burst > 0) begin
        stall_burst--;
        result_stall <= 1'b1;
      end else if (sent < QUIET_AFTER && $urandom_range(0, 5) == 0) begin
        stall_burst = $urandom_range(0, 6);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [255:0] pval;
    errors = 0;
    sent = 0;
    cycles = 0;
    rst = 1'b1;
    y_valid = 1'b0;
    result_stall = 1'b0;
    y_word_0 = '0;
    y_word_1 = '0;
    y_word_2 = '0;
    y_word_3 = '0;
    pval = {1'b0, P};

    add_point(256'd0, 0);
    add_point(256'd1, 0);
    add_point(256'd1 | (256'd1 << 255), 0);
    add_point(pval - 1, 0);
    add_point(pval, 0);
    add_point(pval + 1, 0);
    add_point(pval + 2, 0);
    add_point({1'b1, 255'd0}, 0);
    add_point({256{1'b1}}, 0);
    add_point({1'b0, {255{1'b1}}}, 0);
    add_point(256'd2, 0);
    add_point(256'd3, 0);
    add_point(256'd1 << 254, 0);
    add_point({4{64'h5555_5555_5555_5555}}, 0);
    add_point({4{64'haaaa_aaaa_aaaa_aaaa}}, 0);
    add_point(pval - 2, 0);
    add_point({1'b0, D}, 0);
    add_point({1'b1, PM1}, 0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0: pval = {1'b0, P} + 256'($urandom_range(0, 18)) - 256'd9
                  + (256'($urandom_range(0, 1)) << 255);
        1: pval = {1'($urandom_range(0, 1)), 191'd0, rand64()};
        default: pval = {rand64(), rand64(), rand64(), rand64()};
      endcase
      add_point(pval, i == 120 || i == 200);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || y_valid) @(posedge clk);
    while (expected_on_curve.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ed_pkg.sv
hw/rtl/ed_rf.sv
hw/rtl/ed_mul.sv
hw/rtl/ed25519_point_on_curve_check_unit.sv
tb/ed25519_point_on_curve_check_unit_tb.sv
